// ===== sv/range_booking_first_overflow_core_defines.svh =====
// Assertion macros used by the checker file of the booking checker.
`ifndef RANGE_BOOKING_FIRST_OVERFLOW_CORE_DEFINES_SVH
`define RANGE_BOOKING_FIRST_OVERFLOW_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBFO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBFO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rbfo_pkg.sv =====
// Shared types, constants and controller interface of the booking checker.
`default_nettype none

package rbfo_pkg;

	// Default sizing of the stores.
	localparam int DEF_MAX_DAYS    = 1024;
	localparam int DEF_MAX_ORDERS  = 1024;
	localparam int DEF_AMOUNT_BITS = 30;

	// Fixed field widths.
	localparam int NUM_DAYS_W = 11;
	localparam int DAY_W      = 10;
	localparam int FFO_W      = 11;

	localparam logic [NUM_DAYS_W-1:0] NUM_DAYS_RESET = 11'd1024;

	// Register word index on the configuration port.
	localparam logic REG_NUM_DAYS = 1'b0;

	// Request opcodes.
	localparam logic OP_CAPACITY = 1'b0;
	localparam logic OP_ORDER    = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CLEAR,
		ST_ORD_RD,
		ST_F_RD,
		ST_F_WR,
		ST_L_RD,
		ST_L_WR,
		ST_SCAN,
		ST_SCAN_END,
		ST_DECIDE,
		ST_DONE
	} rbfo_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic init_search;
		logic set_mid;
		logic clear_wr;
		logic idx_rst;
		logic ord_rd;
		logic f_rd;
		logic f_wr;
		logic l_rd;
		logic l_wr;
		logic oi_inc;
		logic scan_rd;
		logic decide;
		logic load_result;
	} rbfo_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic final_req;
		logic search_go;
		logic idx_last;
		logic order_empty;
		logic order_last;
		logic fail;
		logic out_free;
	} rbfo_status_t;

endpackage

`default_nettype wire

// ===== sv/range_booking_first_overflow_core.sv =====
// Top level of the range booking checker: configuration register, controller and datapath.
//
// Use: after setting num_days over the register port, send one capacity request
// (opcode 0) per day, then the booking orders (opcode 1). The order that carries
// final_order starts a binary search over the order prefix length and yields one
// result: all_fit, the 1-based first_failing_order and orders_dropped.
// Capacity and order requests are taken one per cycle while the controller is idle.
// The final order takes about ceil(log2(N + 1)) probes for N stored orders; a
// probe of prefix length P over D days clears the difference store, does a
// read-modify-write on the single-port difference store for each of the P
// orders with a non-empty range, then scans the days up to the first overflow,
// and ends with the search bookkeeping. No request is taken during the search.
// The result sits in an output register; new requests are accepted while it
// waits, and a later search only completes once the receiver has taken it.
// Reset clears the counters, the drop flag and the handshake state and sets
// num_days to 1024; the stores are not cleared, and the capacities survive a
// result so that a new job can reuse them.
`default_nettype none

module range_booking_first_overflow_core
	import rbfo_pkg::*;
#(
	parameter int MAX_DAYS    = DEF_MAX_DAYS,
	parameter int MAX_ORDERS  = DEF_MAX_ORDERS,
	parameter int AMOUNT_BITS = DEF_AMOUNT_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration port.
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [2:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// Request channel.
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   opcode,
	input  wire logic [AMOUNT_BITS-1:0] amount,
	input  wire logic [DAY_W-1:0]       first_day,
	input  wire logic [DAY_W-1:0]       last_day,
	input  wire logic                   final_order,
	// Result channel.
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        all_fit,
	output logic [FFO_W-1:0]            first_failing_order,
	output logic                        orders_dropped
);

	logic [NUM_DAYS_W-1:0] num_days_q;
	rbfo_cmd_t             cmd;
	rbfo_status_t          status;

	// Register port; pready is always high.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_days_q <= NUM_DAYS_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_NUM_DAYS) begin
			num_days_q <= pwdata[NUM_DAYS_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_NUM_DAYS) ?
		{{(32 - NUM_DAYS_W){1'b0}}, num_days_q} : 32'd0;

	// Search sequencer.
	rbfo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	// Stores and arithmetic.
	rbfo_dp #(
		.MAX_DAYS    (MAX_DAYS),
		.MAX_ORDERS  (MAX_ORDERS),
		.AMOUNT_BITS (AMOUNT_BITS)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.num_days            (num_days_q),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.opcode              (opcode),
		.amount              (amount),
		.first_day           (first_day),
		.last_day            (last_day),
		.final_order         (final_order),
		.out_ready           (out_ready),
		.out_valid           (out_valid),
		.all_fit             (all_fit),
		.first_failing_order (first_failing_order),
		.orders_dropped      (orders_dropped)
	);

endmodule

`default_nettype wire

// ===== sv/rbfo_ctrl.sv =====
// Sequencer of the binary search: clear, order accumulation and day scan per probe.
`default_nettype none

module rbfo_ctrl
	import rbfo_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire rbfo_status_t status,
	output rbfo_cmd_t         cmd,
	output logic              in_ready
);

	rbfo_state_t state_q;
	rbfo_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (status.final_req) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = status.search_go ? ST_CLEAR : ST_DONE;
			end
			ST_CLEAR: begin
				if (status.idx_last) state_d = ST_ORD_RD;
			end
			ST_ORD_RD: begin
				state_d = ST_F_RD;
			end
			ST_F_RD: begin
				if (status.order_empty) begin
					state_d = status.order_last ? ST_SCAN : ST_ORD_RD;
				end else begin
					state_d = ST_F_WR;
				end
			end
			ST_F_WR: begin
				state_d = ST_L_RD;
			end
			ST_L_RD: begin
				state_d = ST_L_WR;
			end
			ST_L_WR: begin
				state_d = status.order_last ? ST_SCAN : ST_ORD_RD;
			end
			ST_SCAN: begin
				if (status.fail) begin
					state_d = ST_DECIDE;
				end else if (status.idx_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = ST_CHECK;
			end
			ST_DONE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready         = 1'b1;
				cmd.init_search  = status.final_req;
			end
			ST_CHECK: begin
				cmd.set_mid = status.search_go;
			end
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				cmd.idx_rst  = status.idx_last;
			end
			ST_ORD_RD: begin
				cmd.ord_rd = 1'b1;
			end
			ST_F_RD: begin
				if (status.order_empty) begin
					cmd.oi_inc = !status.order_last;
				end else begin
					cmd.f_rd = 1'b1;
				end
			end
			ST_F_WR: begin
				cmd.f_wr = 1'b1;
			end
			ST_L_RD: begin
				cmd.l_rd = 1'b1;
			end
			ST_L_WR: begin
				cmd.l_wr   = 1'b1;
				cmd.oi_inc = !status.order_last;
			end
			ST_SCAN: begin
				cmd.scan_rd = !status.fail;
			end
			ST_SCAN_END: begin
				cmd = '0;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
			end
			ST_DONE: begin
				cmd.load_result = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/rbfo_dp.sv =====
// Stores, counters, search bounds, difference update and day scan of the booking checker.
`default_nettype none

module rbfo_dp
	import rbfo_pkg::*;
#(
	parameter int MAX_DAYS    = DEF_MAX_DAYS,
	parameter int MAX_ORDERS  = DEF_MAX_ORDERS,
	parameter int AMOUNT_BITS = DEF_AMOUNT_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire rbfo_cmd_t              cmd,
	output rbfo_status_t                status,
	input  wire logic [NUM_DAYS_W-1:0]  num_days,
	input  wire logic                   in_valid,
	input  wire logic                   in_ready,
	input  wire logic                   opcode,
	input  wire logic [AMOUNT_BITS-1:0] amount,
	input  wire logic [DAY_W-1:0]       first_day,
	input  wire logic [DAY_W-1:0]       last_day,
	input  wire logic                   final_order,
	input  wire logic                   out_ready,
	output logic                        out_valid,
	output logic                        all_fit,
	output logic [FFO_W-1:0]            first_failing_order,
	output logic                        orders_dropped
);

	localparam int DAW = $clog2(MAX_DAYS);
	localparam int DCW = $clog2(MAX_DAYS + 1);
	localparam int OAW = $clog2(MAX_ORDERS);
	localparam int SW  = $clog2(MAX_ORDERS + 2);
	localparam int DW  = AMOUNT_BITS + $clog2(MAX_ORDERS + 1) + 1;
	localparam int OW  = AMOUNT_BITS + 2 * DAY_W;

	// Stores.
	logic [AMOUNT_BITS-1:0] cap_mem   [0:MAX_DAYS-1];
	logic [OW-1:0]          order_mem [0:MAX_ORDERS-1];
	logic signed [DW-1:0]   diff_mem  [0:MAX_DAYS];

	// Control registers.
	logic [DCW-1:0] day_cnt_q;
	logic [SW-1:0]  ord_cnt_q;
	logic           drop_q;
	logic [SW-1:0]  lo_q;
	logic [SW-1:0]  hi_q;
	logic [SW-1:0]  mid_q;
	logic [DCW-1:0] idx_q;
	logic [SW-1:0]  oi_q;
	logic           fail_q;
	logic           vld_s1;
	logic           out_valid_q;

	// Payload registers.
	logic [OW-1:0]          ord_rd_q;
	logic signed [DW-1:0]   diff_rd_q;
	logic [AMOUNT_BITS-1:0] cap_rd_s1;
	logic signed [DW-1:0]   run_q;
	logic                   all_fit_q;
	logic [FFO_W-1:0]       ffo_q;
	logic                   dropped_q;

	logic [31:0]      nd32;
	logic [31:0]      days32;
	logic [DCW-1:0]   days;
	logic             accept;
	logic             day_room;
	logic             ord_room;
	logic [SW:0]      mid_sum;
	logic [AMOUNT_BITS-1:0] ord_amt;
	logic [31:0]      f32;
	logic [31:0]      l32;
	logic [31:0]      lc32;
	logic [31:0]      l1_32;
	logic [31:0]      dm1_32;
	logic             ord_empty;
	logic [DCW-1:0]   diff_addr;
	logic signed [DW-1:0] amt_ext;
	logic signed [DW-1:0] diff_wdata;
	logic             diff_we;
	logic signed [DW-1:0] scan_sum;
	logic             scan_over;
	logic             result_fit;
	logic [31:0]      hi32;

	// Days in use: zero acts as one, anything above the store depth as the depth.
	assign nd32 = {{(32 - NUM_DAYS_W){1'b0}}, num_days};
	always_comb begin
		if (nd32 == 32'd0) begin
			days32 = 32'd1;
		end else if (nd32 > 32'(MAX_DAYS)) begin
			days32 = 32'(MAX_DAYS);
		end else begin
			days32 = nd32;
		end
	end
	assign days = days32[DCW-1:0];

	// Request decode.
	assign accept   = in_valid && in_ready;
	assign day_room = 32'(day_cnt_q) < days32;
	assign ord_room = 32'(ord_cnt_q) < 32'(MAX_ORDERS);

	// Current order, clamped to the days in use.
	assign ord_amt   = ord_rd_q[OW-1 -: AMOUNT_BITS];
	assign f32       = {{(32 - DAY_W){1'b0}}, ord_rd_q[2*DAY_W-1 -: DAY_W]};
	assign l32       = {{(32 - DAY_W){1'b0}}, ord_rd_q[DAY_W-1:0]};
	assign dm1_32    = days32 - 32'd1;
	assign lc32      = (l32 > dm1_32) ? dm1_32 : l32;
	assign l1_32     = lc32 + 32'd1;
	assign ord_empty = f32 > lc32;
	assign amt_ext   = $signed({{(DW - AMOUNT_BITS){1'b0}}, ord_amt});

	// Difference store address and write data.
	always_comb begin
		if (cmd.f_rd || cmd.f_wr) begin
			diff_addr = f32[DCW-1:0];
		end else if (cmd.l_rd || cmd.l_wr) begin
			diff_addr = l1_32[DCW-1:0];
		end else begin
			diff_addr = idx_q;
		end
	end

	always_comb begin
		if (cmd.f_wr) begin
			diff_wdata = diff_rd_q + amt_ext;
		end else if (cmd.l_wr) begin
			diff_wdata = diff_rd_q - amt_ext;
		end else begin
			diff_wdata = '0;
		end
	end
	assign diff_we = cmd.clear_wr || cmd.f_wr || cmd.l_wr;

	// Running load of the scan against the capacity of the same day.
	assign scan_sum  = run_q + diff_rd_q;
	assign scan_over = vld_s1 && (scan_sum > $signed({{(DW - AMOUNT_BITS){1'b0}}, cap_rd_s1}));

	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign result_fit = lo_q == ord_cnt_q;
	assign hi32       = 32'(hi_q);

	// Capacity and order stores.
	always_ff @(posedge clk) begin
		if (accept && opcode == OP_CAPACITY && day_room) begin
			cap_mem[day_cnt_q[DAW-1:0]] <= amount;
		end
		if (accept && opcode == OP_ORDER && ord_room) begin
			order_mem[ord_cnt_q[OAW-1:0]] <= {amount, first_day, last_day};
		end
		if (cmd.ord_rd) begin
			ord_rd_q <= order_mem[oi_q[OAW-1:0]];
		end
		if (cmd.scan_rd) begin
			cap_rd_s1 <= cap_mem[idx_q[DAW-1:0]];
		end
	end

	// Difference store, one read and one write port.
	always_ff @(posedge clk) begin
		if (diff_we) begin
			diff_mem[diff_addr] <= diff_wdata;
		end
		if (cmd.f_rd || cmd.l_rd || cmd.scan_rd) begin
			diff_rd_q <= diff_mem[diff_addr];
		end
	end

	// Running sum of the scan.
	always_ff @(posedge clk) begin
		if (cmd.set_mid) begin
			run_q <= '0;
		end else if (vld_s1) begin
			run_q <= scan_sum;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			all_fit_q <= result_fit;
			ffo_q     <= result_fit ? '0 : hi32[FFO_W-1:0];
			dropped_q <= drop_q;
		end
	end

	// Counters, search bounds and handshake state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_cnt_q   <= '0;
			ord_cnt_q   <= '0;
			drop_q      <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			idx_q       <= '0;
			oi_q        <= '0;
			fail_q      <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_rd;

			if (cmd.load_result) begin
				day_cnt_q <= '0;
				ord_cnt_q <= '0;
				drop_q    <= 1'b0;
			end else if (accept) begin
				if (opcode == OP_CAPACITY) begin
					if (day_room) day_cnt_q <= day_cnt_q + DCW'(1);
				end else if (ord_room) begin
					ord_cnt_q <= ord_cnt_q + SW'(1);
				end else begin
					drop_q <= 1'b1;
				end
			end

			if (cmd.init_search) begin
				lo_q <= '0;
				hi_q <= ord_room ? ord_cnt_q + SW'(2) : ord_cnt_q + SW'(1);
			end else if (cmd.decide) begin
				if (fail_q) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q;
				end
			end

			if (cmd.set_mid) begin
				mid_q <= mid_sum[SW:1];
			end

			if (cmd.set_mid || cmd.idx_rst) begin
				idx_q <= '0;
			end else if (cmd.clear_wr || cmd.scan_rd) begin
				idx_q <= idx_q + DCW'(1);
			end

			if (cmd.set_mid) begin
				oi_q <= '0;
			end else if (cmd.oi_inc) begin
				oi_q <= oi_q + SW'(1);
			end

			if (cmd.set_mid) begin
				fail_q <= 1'b0;
			end else if (scan_over) begin
				fail_q <= 1'b1;
			end

			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Status towards the controller.
	always_comb begin
		status.final_req   = accept && opcode == OP_ORDER && final_order;
		status.search_go   = ({1'b0, lo_q} + {{SW{1'b0}}, 1'b1}) < {1'b0, hi_q};
		status.idx_last    = idx_q == (days - DCW'(1));
		status.order_empty = ord_empty;
		status.order_last  = (oi_q + SW'(1)) == mid_q;
		status.fail        = fail_q;
		status.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid           = out_valid_q;
	assign all_fit             = all_fit_q;
	assign first_failing_order = ffo_q;
	assign orders_dropped      = dropped_q;

endmodule

`default_nettype wire

// ===== sv/rbfo_checker.sv =====
// Port-level checks of the booking checker and their binding to the top level.
`default_nettype none

`include "range_booking_first_overflow_core_defines.svh"

module rbfo_checker
	import rbfo_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             opcode,
	input wire logic             final_order,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic             all_fit,
	input wire logic [FFO_W-1:0] first_failing_order,
	input wire logic             orders_dropped
);

	logic final_req;

	assign final_req = in_valid && in_ready && opcode == OP_ORDER && final_order;

	// A stalled result keeps its payload.
	`RBFO_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(all_fit) && $stable(first_failing_order) && $stable(orders_dropped), "result changed while stalled")

	// A final order stops further requests while the search runs.
	`RBFO_ASSERT_NXT(a_final_blocks, clk, arst_n, final_req, !in_ready, "request taken after final order")

	// A fitting job reports no failing order.
	`RBFO_ASSERT_IMP(a_fit_index, clk, arst_n, out_valid && all_fit, first_failing_order == '0, "failing index on fitting job")

	// A new result is only raised at the end of a search.
	`RBFO_ASSERT_IMP(a_result_after_search, clk, arst_n, $rose(out_valid), $past(!in_ready), "result without a search")

endmodule

bind range_booking_first_overflow_core rbfo_checker u_rbfo_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.in_valid            (in_valid),
	.in_ready            (in_ready),
	.opcode              (opcode),
	.final_order         (final_order),
	.out_valid           (out_valid),
	.out_ready           (out_ready),
	.all_fit             (all_fit),
	.first_failing_order (first_failing_order),
	.orders_dropped      (orders_dropped)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the range booking checker: first overbooking order search.
`timescale 1ns / 1ps

module tb_top;
	import rbfo_pkg::*;

	localparam int DAYS_MAX       = DEF_MAX_DAYS;
	localparam int ORDERS_MAX     = DEF_MAX_ORDERS;
	localparam int AW             = DEF_AMOUNT_BITS;
	localparam int REQUEST_TARGET = 1500;
	localparam int SETTLE_CYCLES  = 20;

	// One verdict of a booking job, as the result channel carries it.
	typedef struct {
		logic                 fit;
		logic [FFO_W-1:0]     first_bad;
		logic                 dropped;
	} verdict_t;

	// Keeps a private copy of the capacities and orders, works out the verdict of
	// each job when its final order is taken, and checks the verdicts that come out.
	class booking_ledger;
		logic [AW-1:0]         cap_by_day [DAYS_MAX];
		logic [AW-1:0]         ord_amount [ORDERS_MAX];
		logic [DAY_W-1:0]      ord_first [ORDERS_MAX];
		logic [DAY_W-1:0]      ord_last [ORDERS_MAX];
		logic [NUM_DAYS_W-1:0] days_reg;
		int unsigned           days_loaded;
		int unsigned           days_written;
		int unsigned           orders_held;
		logic                  dropped;
		verdict_t              verdicts_due [$];
		int unsigned           verdicts_seen;
		int unsigned           mismatches;

		function new();
			days_reg      = NUM_DAYS_RESET;
			days_loaded   = 0;
			days_written  = 0;
			orders_held   = 0;
			dropped       = 1'b0;
			verdicts_seen = 0;
			mismatches    = 0;
		endfunction

		// A day count of zero behaves as one, and anything above the store as the store size.
		function int unsigned active_days();
			if (days_reg == 0)
				return 1;
			if (days_reg > DAYS_MAX)
				return DAYS_MAX;
			return days_reg;
		endfunction

		// Books the first len orders into a difference array and sweeps it against the capacities.
		function bit prefix_within_capacity(int unsigned len);
			longint      day_delta [DAYS_MAX+1];
			longint      running;
			int unsigned days, stop, i;
			days    = active_days();
			running = 0;
			for (i = 0; i <= DAYS_MAX; i++)
				day_delta[i] = 0;
			for (i = 0; i < len; i++) begin
				stop = (ord_last[i] > days - 1) ? days - 1 : ord_last[i];
				if (ord_first[i] <= stop) begin
					day_delta[ord_first[i]] += longint'(ord_amount[i]);
					day_delta[stop + 1]     -= longint'(ord_amount[i]);
				end
			end
			for (i = 0; i < days; i++) begin
				running += day_delta[i];
				if (running > longint'(cap_by_day[i]))
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_request(logic op, logic [AW-1:0] amt, logic [DAY_W-1:0] fd,
				logic [DAY_W-1:0] ld, logic fin);
			int unsigned days, lo, hi, mid;
			verdict_t    v;
			days = active_days();
			// Capacities fill the next day in turn; surplus ones are ignored.
			if (op == OP_CAPACITY) begin
				if (days_loaded < days) begin
					cap_by_day[days_loaded] = amt;
					days_loaded++;
					if (days_loaded > days_written)
						days_written = days_loaded;
				end
				return;
			end
			// Orders beyond the store are lost but remembered in the drop flag.
			if (orders_held < ORDERS_MAX) begin
				ord_amount[orders_held] = amt;
				ord_first[orders_held]  = fd;
				ord_last[orders_held]   = ld;
				orders_held++;
			end else begin
				dropped = 1'b1;
			end
			if (!fin)
				return;
			// Binary search for the longest prefix that still fits.
			lo = 0;
			hi = orders_held + 1;
			while (lo + 1 < hi) begin
				mid = (lo + hi) >> 1;
				if (prefix_within_capacity(mid))
					lo = mid;
				else
					hi = mid;
			end
			v.fit       = (lo == orders_held);
			v.first_bad = v.fit ? '0 : FFO_W'(hi);
			v.dropped   = dropped;
			verdicts_due.push_back(v);
			orders_held = 0;
			days_loaded = 0;
			dropped     = 1'b0;
		endfunction

		function void check_verdict(logic fit, logic [FFO_W-1:0] first_bad, logic drop);
			verdict_t due;
			verdicts_seen++;
			if (verdicts_due.size() == 0) begin
				$error("unexpected verdict: all_fit %0d first_failing_order %0d orders_dropped %0d",
					fit, first_bad, drop);
				mismatches++;
				return;
			end
			due = verdicts_due.pop_front();
			if (fit !== due.fit) begin
				$error("all_fit: expected %0d, got %0d", due.fit, fit);
				mismatches++;
			end
			if (first_bad !== due.first_bad) begin
				$error("first_failing_order: expected %0d, got %0d", due.first_bad, first_bad);
				mismatches++;
			end
			if (drop !== due.dropped) begin
				$error("orders_dropped: expected %0d, got %0d", due.dropped, drop);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [2:0]           paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 opcode = 1'b0;
	logic [AW-1:0]        amount = '0;
	logic [DAY_W-1:0]     first_day = '0;
	logic [DAY_W-1:0]     last_day = '0;
	logic                 final_order = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 all_fit;
	logic [FFO_W-1:0]     first_failing_order;
	logic                 orders_dropped;

	booking_ledger ledger = new();

	bit          steady_sender = 1'b0;
	int unsigned ready_left = 0;
	int unsigned jobs_run = 0;
	int unsigned orders_sent = 0;
	int unsigned requests_sent = 0;
	int unsigned settings_used = 0;

	range_booking_first_overflow_core dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: ready stretches and stalls of random length, mostly short.
	always @(posedge clk) begin
		if (ready_left != 0) begin
			ready_left--;
		end else if (out_ready) begin
			out_ready <= 1'b0;
			case ($urandom_range(0, 19))
				0:       ready_left = $urandom_range(50, 200);
				1, 2, 3: ready_left = $urandom_range(4, 20);
				default: ready_left = $urandom_range(0, 3);
			endcase
		end else begin
			out_ready <= 1'b1;
			ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
				: $urandom_range(0, 30);
		end
	end

	// Every verdict taken by the receiver is checked against the oldest one due.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_verdict(all_fit, first_failing_order, orders_dropped);
	end

	function automatic int unsigned draw_gap();
		int unsigned roll;
		if (steady_sender)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// A value up to top, full range when top is zero, with the extremes now and then.
	function automatic logic [AW-1:0] pick_value(input int unsigned top);
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		if (top == 0)
			return AW'($urandom);
		return AW'($urandom_range(0, top));
	endfunction

	// Presents one request, waits for it to be taken, then idles for a random gap.
	task automatic send_request(input logic op, input logic [AW-1:0] amt,
			input logic [DAY_W-1:0] fd, input logic [DAY_W-1:0] ld, input logic fin);
		int unsigned gap;
		in_valid    <= 1'b1;
		opcode      <= op;
		amount      <= amt;
		first_day   <= fd;
		last_day    <= ld;
		final_order <= fin;
		do @(posedge clk); while (!in_ready);
		ledger.note_request(op, amt, fd, ld, fin);
		requests_sent++;
		gap = draw_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Holds the sender back until every verdict due has been taken and the search has wound down.
	task automatic drain_verdicts();
		in_valid <= 1'b0;
		do @(posedge clk); while (ledger.verdicts_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_num_days(input logic [NUM_DAYS_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_NUM_DAYS, 2'b00};
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		ledger.days_reg = value;
		settings_used++;
	endtask

	// One job: optional capacity reload, then a list of orders ending in the final one.
	task automatic run_job(input bit short_list);
		int unsigned      days, load_n, n_orders, cap_top, amt_top, lo_day, i;
		logic [DAY_W-1:0] fd, ld;
		days          = ledger.active_days();
		steady_sender = ($urandom_range(0, 3) == 0);
		case ($urandom_range(0, 9))
			0, 1: begin
				cap_top = 0;
				amt_top = 0;
			end
			8, 9: begin
				cap_top = 1_000_000;
				amt_top = 2000;
			end
			default: begin
				cap_top = 1000;
				amt_top = 300;
			end
		endcase
		if (short_list)
			n_orders = $urandom_range(1, 8);
		else if ($urandom_range(0, 99) < 70)
			n_orders = $urandom_range(1, 8);
		else if ($urandom_range(0, 4) != 0)
			n_orders = $urandom_range(9, 30);
		else
			n_orders = $urandom_range(31, 80);

		// Every day in use must hold a capacity before the search reads it.
		if (ledger.days_written < days)
			load_n = days + $urandom_range(0, 2);
		else if ((days <= 300) ? ($urandom_range(0, 9) < 6) : ($urandom_range(0, 9) == 0))
			load_n = $urandom_range(1, days + 2);
		else
			load_n = 0;
		for (i = 0; i < load_n; i++)
			send_request(OP_CAPACITY, pick_value(cap_top), DAY_W'($urandom), DAY_W'($urandom),
				1'($urandom));

		for (i = 0; i < n_orders; i++) begin
			// A stray capacity request in the middle of the order list.
			if ($urandom_range(0, 19) == 0)
				send_request(OP_CAPACITY, pick_value(cap_top), DAY_W'($urandom),
					DAY_W'($urandom), 1'($urandom));
			if ($urandom_range(0, 4) == 0) begin
				fd = DAY_W'($urandom);
				ld = DAY_W'($urandom);
			end else begin
				lo_day = $urandom_range(0, days - 1);
				fd = DAY_W'(lo_day);
				ld = ($urandom_range(0, 9) == 0) ? DAY_W'($urandom_range(0, days - 1))
					: DAY_W'($urandom_range(lo_day, days - 1));
			end
			send_request(OP_ORDER, pick_value(amt_top), fd, ld, 1'(i == n_orders - 1));
			orders_sent++;
		end
		jobs_run++;
	endtask

	// Overfills the order store over five days: the orders before the last stored one
	// cannot add up past the capacity, the last stored one overbooks, the rest are dropped.
	task automatic full_store_job();
		int unsigned      i;
		logic [DAY_W-1:0] fd;
		for (i = 0; i < 5; i++)
			send_request(OP_CAPACITY, AW'(3000), '0, '0, 1'b0);
		for (i = 1; i <= ORDERS_MAX + 4; i++) begin
			if (i == ORDERS_MAX) begin
				send_request(OP_ORDER, '1, '0, '1, 1'b0);
			end else begin
				fd = DAY_W'($urandom_range(0, 4));
				send_request(OP_ORDER, AW'($urandom_range(0, 2)), fd,
					DAY_W'($urandom_range(fd, 4)), 1'(i == ORDERS_MAX + 4));
			end
			orders_sent++;
		end
		jobs_run++;
	endtask

	initial begin
		int unsigned                 phase, jobs, j;
		logic [NUM_DAYS_W-1:0]       setting;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Three days: largest and zero capacity, a surplus capacity carrying the final flag.
		write_num_days(11'd3);
		send_request(OP_CAPACITY, 30'h3FFF_FFFF, 10'd1023, 10'd0, 1'b0);
		send_request(OP_CAPACITY, 30'd0, 10'd0, 10'd1023, 1'b0);
		send_request(OP_CAPACITY, 30'd5, 10'd0, 10'd0, 1'b0);
		send_request(OP_CAPACITY, 30'd7, 10'd0, 10'd0, 1'b1);
		// Zero amount, a full-capacity day, a clamped last day, an empty range,
		// an overbooking fifth order, and a first day past the clamp.
		send_request(OP_ORDER, 30'd0, 10'd1, 10'd1, 1'b0);
		send_request(OP_ORDER, 30'h3FFF_FFFF, 10'd0, 10'd0, 1'b0);
		send_request(OP_ORDER, 30'd5, 10'd2, 10'd1023, 1'b0);
		send_request(OP_ORDER, 30'd7, 10'd2, 10'd0, 1'b0);
		send_request(OP_ORDER, 30'd1, 10'd1, 10'd1023, 1'b0);
		send_request(OP_ORDER, 30'd3, 10'd1023, 10'd1023, 1'b1);
		// Jobs reusing the kept capacities: all fit, then the very first order fails.
		send_request(OP_ORDER, 30'd0, 10'd0, 10'd1023, 1'b1);
		send_request(OP_ORDER, 30'd6, 10'd2, 10'd2, 1'b1);
		drain_verdicts();

		// A day count of zero acts as a single day.
		write_num_days(11'd0);
		send_request(OP_CAPACITY, 30'd1, 10'd0, 10'd0, 1'b0);
		send_request(OP_CAPACITY, 30'h2AAA_AAAA, 10'd0, 10'd0, 1'b0);
		send_request(OP_ORDER, 30'd2, 10'd0, 10'd1023, 1'b1);
		send_request(OP_ORDER, 30'h1555_5555, 10'd1023, 10'd0, 1'b1);
		orders_sent = 10;
		jobs_run    = 5;

		// Random phases, each under its own day count; the second one overfills the order store.
		phase = 0;
		while (requests_sent < REQUEST_TARGET) begin
			if (phase == 1) begin
				setting = 11'd5;
			end else begin
				case ($urandom_range(0, 9))
					0:       setting = NUM_DAYS_W'($urandom_range(0, 1));
					7, 8:    setting = NUM_DAYS_W'($urandom_range(17, 64));
					9:       setting = NUM_DAYS_W'($urandom_range(65, 300));
					default: setting = NUM_DAYS_W'($urandom_range(2, 16));
				endcase
			end
			drain_verdicts();
			write_num_days(setting);
			if (phase == 1) begin
				full_store_job();
			end else begin
				jobs = $urandom_range(2, 10);
				for (j = 0; j < jobs; j++)
					run_job(1'b0);
			end
			phase++;
		end
		drain_verdicts();

		$display("Covered %0d booking jobs with %0d orders, %0d requests in all, under %0d day counts,",
			jobs_run, orders_sent, requests_sent, settings_used);
		$display("including an overfilled order store and a zero day count; %0d verdicts checked.",
			ledger.verdicts_seen);
		if (ledger.mismatches == 0)
			$display("range_booking_first_overflow_core: match");
		else
			$display("range_booking_first_overflow_core: mismatch");
		$finish;
	end

	// Watchdog: 100 ms is several times the slowest run that can pass.
	initial begin
		#100_000_000;
		$display("range_booking_first_overflow_core: mismatch");
		$finish;
	end

endmodule
